FILE: hw/rtl/vfsp_pkg.sv
// view frustum side planes: shared widths, codes, transaction tags and helpers
// used by the channel interfaces, the unit normal pipeline and the top level
package vfsp_pkg;

	localparam int POS_W     = 48;
	localparam int VEC_W     = 32;
	localparam int TAN_W     = 32;
	localparam int CFG_IDX_W = 2;

	// normalized normal magnitude, its sum of squares, length and quotient
	localparam int MAG_W     = 30;
	localparam int SUM_W     = 2 * MAG_W + 2;
	localparam int LEN_W     = MAG_W + 1;
	localparam int Q_W       = MAG_W + 1;
	localparam int SQ_STEPS  = SUM_W / 2;
	localparam int DIV_STEPS = Q_W;

	localparam logic [1:0] PLANE_LEFT   = 2'd0;
	localparam logic [1:0] PLANE_RIGHT  = 2'd1;
	localparam logic [1:0] PLANE_BOTTOM = 2'd2;
	localparam logic [1:0] PLANE_TOP    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_TAN_H = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAN_V = 2'd1;

	localparam logic [TAN_W-1:0] TAN_RESET = 32'h0100_0000;

	localparam logic signed [31:0] NORM_LIM = 32'sh4000_0000;
	localparam logic signed [31:0] NORM_MIN = -32'sh4000_0000;

	localparam logic signed [POS_W-1:0] OFF_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [POS_W-1:0] OFF_MIN = 48'sh8000_0000_0000;

	typedef struct packed {
		logic [1:0]                idx;
		logic [2:0][POS_W-1:0]     pos;
	} tag_t;

	typedef struct packed {
		tag_t       tag;
		logic       deg;
		logic [2:0] neg;
	} carry_t;

	// smallest right shift that brings x into signed 32 bits
	function automatic logic [3:0] fit_shift(input logic signed [45:0] x);
		logic signed [45:0] hi;
		logic [3:0]         r;
		r = 4'd14;
		for (int k = 14; k >= 0; k--) begin
			hi = x >>> (31 + k);
			if (hi == '0 || hi == '1) r = 4'(k);
		end
		return r;
	endfunction

	function automatic logic [5:0] lead_one(input logic [63:0] v);
		logic [5:0] r;
		r = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) r = 6'(i);
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/vfsp_if.sv
// valid/ready channels for camera poses in and frustum planes out
// depends on vfsp_pkg for field widths
interface vfsp_pose_if import vfsp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic signed [VEC_W-1:0] dir_x;
	logic signed [VEC_W-1:0] dir_y;
	logic signed [VEC_W-1:0] dir_z;
	logic signed [VEC_W-1:0] up_x;
	logic signed [VEC_W-1:0] up_y;
	logic signed [VEC_W-1:0] up_z;

	modport source (output valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
		up_x, up_y, up_z, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
		up_x, up_y, up_z, output ready);
endinterface

interface vfsp_plane_if import vfsp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              plane_index;
	logic signed [VEC_W-1:0] normal_x;
	logic signed [VEC_W-1:0] normal_y;
	logic signed [VEC_W-1:0] normal_z;
	logic signed [POS_W-1:0] plane_offset;
	logic                    degenerate;
	logic                    last_plane;

	modport source (output valid, plane_index, normal_x, normal_y, normal_z,
		plane_offset, degenerate, last_plane, input ready);
	modport sink (input valid, plane_index, normal_x, normal_y, normal_z,
		plane_offset, degenerate, last_plane, output ready);
endinterface

FILE: hw/rtl/vfsp_unitize.sv
// unit normal pipeline: integer square root of the sum of squares, then
// rounded division of each magnitude by the length; depends on vfsp_pkg
module vfsp_unitize import vfsp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [SUM_W-1:0]         sum_sq,
	input  logic [2:0][MAG_W-1:0]    mag,
	input  carry_t                   in_carry,
	output logic                     out_valid,
	output logic [2:0][Q_W-1:0]      q,
	output carry_t                   out_carry
);

	// square root, one bit pair per stage
	logic                  sq_v [SQ_STEPS];
	logic [SUM_W-1:0]      sq_x [SQ_STEPS];
	logic [SUM_W-1:0]      sq_r [SQ_STEPS];
	logic [2:0][MAG_W-1:0] sq_m [SQ_STEPS];
	carry_t                sq_c [SQ_STEPS];

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
		localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQ_STEPS - 1 - j));
		logic                  v_in;
		logic [SUM_W-1:0]      x_in, r_in, trial;
		logic [2:0][MAG_W-1:0] m_in;
		carry_t                c_in;

		if (j == 0) begin : g_first
			assign v_in = in_valid;
			assign x_in = sum_sq;
			assign r_in = '0;
			assign m_in = mag;
			assign c_in = in_carry;
		end else begin : g_next
			assign v_in = sq_v[j-1];
			assign x_in = sq_x[j-1];
			assign r_in = sq_r[j-1];
			assign m_in = sq_m[j-1];
			assign c_in = sq_c[j-1];
		end

		assign trial = r_in + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[j] <= 1'b0;
			end else if (en) begin
				sq_v[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (x_in >= trial) begin
					sq_x[j] <= x_in - trial;
					sq_r[j] <= (r_in >> 1) + BIT;
				end else begin
					sq_x[j] <= x_in;
					sq_r[j] <= r_in >> 1;
				end
				sq_m[j] <= m_in;
				sq_c[j] <= c_in;
			end
		end
	end

	// division, one quotient bit per stage; stage 0 forms the rounded dividend
	logic                        dv_v  [DIV_STEPS+1];
	logic [2:0][LEN_W-1:0]       dv_r  [DIV_STEPS+1];
	logic [2:0][Q_W-1:0]         dv_lo [DIV_STEPS+1];
	logic [2:0][Q_W-1:0]         dv_q  [DIV_STEPS+1];
	logic [LEN_W-1:0]            dv_d  [DIV_STEPS+1];
	carry_t                      dv_c  [DIV_STEPS+1];

	logic [LEN_W-1:0] len;
	assign len = sq_r[SQ_STEPS-1][LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0] <= sq_v[SQ_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		logic [MAG_W+Q_W-1:0] num;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num = (MAG_W+Q_W)'({sq_m[SQ_STEPS-1][i], {MAG_W{1'b0}}})
					+ (MAG_W+Q_W)'(len >> 1);
				dv_r[0][i]  <= LEN_W'(num[MAG_W+Q_W-1:Q_W]);
				dv_lo[0][i] <= num[Q_W-1:0];
				dv_q[0][i]  <= '0;
			end
			dv_d[0] <= len;
			dv_c[0] <= sq_c[SQ_STEPS-1];
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else if (en) begin
				dv_v[j+1] <= dv_v[j];
			end
		end

		always_ff @(posedge clk) begin
			logic [LEN_W:0] t;
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					t = {dv_r[j][i], dv_lo[j][i][Q_W-1]};
					if (t >= {1'b0, dv_d[j]}) begin
						dv_r[j+1][i] <= LEN_W'(t - {1'b0, dv_d[j]});
						dv_q[j+1][i] <= {dv_q[j][i][Q_W-2:0], 1'b1};
					end else begin
						dv_r[j+1][i] <= t[LEN_W-1:0];
						dv_q[j+1][i] <= {dv_q[j][i][Q_W-2:0], 1'b0};
					end
					dv_lo[j+1][i] <= dv_lo[j][i] << 1;
				end
				dv_d[j+1] <= dv_d[j];
				dv_c[j+1] <= dv_c[j];
			end
		end
	end

	assign out_valid = dv_v[DIV_STEPS];
	assign q         = dv_q[DIV_STEPS];
	assign out_carry = dv_c[DIV_STEPS];

endmodule

FILE: hw/rtl/view_frustum_side_planes.sv
// Side planes of a perspective view frustum. Each accepted camera pose yields four plane
// transactions, left, right, bottom, top, the last flagged by last_plane. A pose is held
// while its four planes are issued into the pipeline one per cycle unless the plane channel
// stalls, so poses follow one another without a gap, paced by the single plane output
// channel. Most of the issue-to-output path is the one-bit-per-stage square root and
// divider. A stall on the plane channel freezes the whole pipeline; the next pose is taken
// into the holding register as soon as the current one has issued its last plane.
// Tangents are written through the configuration port (index 0 horizontal, 1 vertical);
// the user must write them only while no pose is in flight; the block does not enforce it.
module view_frustum_side_planes import vfsp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TAN_W-1:0]     cfg_data,
	vfsp_pose_if.sink            pose,
	vfsp_plane_if.source         plane
);

	logic [TAN_W-1:0] tan_h_q, tan_v_q;
	logic             busy_q;
	logic [1:0]       cnt_q;
	logic             adv;
	logic             out_v_q;

	logic [2:0][POS_W-1:0]    hold_pos_q;
	logic signed [VEC_W-1:0]  hold_dir_q [3];
	logic signed [VEC_W-1:0]  hold_up_q  [3];

	assign adv        = !out_v_q || plane.ready;
	assign pose.ready = !busy_q || (cnt_q == PLANE_TOP && adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tan_h_q <= TAN_RESET;
			tan_v_q <= TAN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TAN_H: tan_h_q <= cfg_data;
				REG_TAN_V: tan_v_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pose holding register and plane sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= PLANE_LEFT;
		end else if (pose.valid && pose.ready) begin
			busy_q <= 1'b1;
			cnt_q  <= PLANE_LEFT;
		end else if (adv && busy_q) begin
			if (cnt_q == PLANE_TOP) busy_q <= 1'b0;
			else cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pose.valid && pose.ready) begin
			hold_pos_q    <= {pose.pos_z, pose.pos_y, pose.pos_x};
			hold_dir_q[0] <= pose.dir_x;
			hold_dir_q[1] <= pose.dir_y;
			hold_dir_q[2] <= pose.dir_z;
			hold_up_q[0]  <= pose.up_x;
			hold_up_q[1]  <= pose.up_y;
			hold_up_q[2]  <= pose.up_z;
		end
	end

	// valid bits of the front stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic v_s13, v_s14, v_s15;
	logic u_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12} <= '0;
			{v_s13, v_s14, v_s15, out_v_q} <= '0;
		end else if (adv) begin
			v_s1  <= busy_q;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= u_valid;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			out_v_q <= v_s15;
		end
	end

	// s1: partial products of right = dir x up
	logic signed [63:0]      pa_s1 [3], pb_s1 [3];
	logic signed [VEC_W-1:0] dir_s1 [3], up_s1 [3];
	tag_t                    tag_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s1[0] <= hold_dir_q[1] * hold_up_q[2];
			pb_s1[0] <= hold_dir_q[2] * hold_up_q[1];
			pa_s1[1] <= hold_dir_q[2] * hold_up_q[0];
			pb_s1[1] <= hold_dir_q[0] * hold_up_q[2];
			pa_s1[2] <= hold_dir_q[0] * hold_up_q[1];
			pb_s1[2] <= hold_dir_q[1] * hold_up_q[0];
			dir_s1   <= hold_dir_q;
			up_s1    <= hold_up_q;
			tag_s1   <= '{idx: cnt_q, pos: hold_pos_q};
		end
	end

	// s2: right vector in q.30
	logic signed [33:0]      right_s2 [3];
	logic signed [VEC_W-1:0] dir_s2 [3], up_s2 [3];
	tag_t                    tag_s2;

	always_ff @(posedge clk) begin
		logic signed [64:0] d;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				d = 65'(pa_s1[i]) - 65'(pb_s1[i]);
				right_s2[i] <= d[63:30];
			end
			dir_s2 <= dir_s1;
			up_s2  <= up_s1;
			tag_s2 <= tag_s1;
		end
	end

	// s3: tangent products split in two halves, fitted right vector
	logic signed [50:0]      hi_s3 [3], lo_s3 [3];
	logic signed [VEC_W-1:0] rfit_s3 [3], dir_s3 [3], up_s3 [3];
	tag_t                    tag_s3;

	logic             horiz_s2;
	logic [TAN_W-1:0] tsel_s2;
	assign horiz_s2 = (tag_s2.idx == PLANE_LEFT) || (tag_s2.idx == PLANE_RIGHT);
	assign tsel_s2  = horiz_s2 ? tan_h_q : tan_v_q;

	always_ff @(posedge clk) begin
		logic signed [33:0] v;
		logic signed [16:0] thi, tlo;
		logic [3:0]         k, kc;
		logic signed [45:0] rx;
		if (adv) begin
			thi = $signed({1'b0, tsel_s2[31:16]});
			tlo = $signed({1'b0, tsel_s2[15:0]});
			k = 4'd0;
			for (int i = 0; i < 3; i++) begin
				v = horiz_s2 ? right_s2[i] : 34'(up_s2[i]);
				hi_s3[i] <= v * thi;
				lo_s3[i] <= v * tlo;
				kc = fit_shift(46'(right_s2[i]));
				if (kc > k) k = kc;
			end
			for (int i = 0; i < 3; i++) begin
				rx = 46'(right_s2[i]) >>> k;
				rfit_s3[i] <= rx[31:0];
			end
			dir_s3 <= dir_s2;
			up_s3  <= up_s2;
			tag_s3 <= tag_s2;
		end
	end

	// s4: side vector dir +/- tan * v
	logic signed [45:0]      s_s4 [3];
	logic signed [VEC_W-1:0] w_s4 [3];
	tag_t                    tag_s4;

	logic minus_s3, horiz_s3;
	assign minus_s3 = (tag_s3.idx == PLANE_LEFT) || (tag_s3.idx == PLANE_BOTTOM);
	assign horiz_s3 = (tag_s3.idx == PLANE_LEFT) || (tag_s3.idx == PLANE_RIGHT);

	always_ff @(posedge clk) begin
		logic signed [50:0] psum;
		logic signed [42:0] p;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				psum = hi_s3[i] + (lo_s3[i] >>> 16);
				p    = psum[50:8];
				s_s4[i] <= minus_s3 ? (46'(dir_s3[i]) - 46'(p)) : (46'(dir_s3[i]) + 46'(p));
				w_s4[i] <= horiz_s3 ? up_s3[i] : rfit_s3[i];
			end
			tag_s4 <= tag_s3;
		end
	end

	// s5: fit side vector into 32 bits
	logic signed [VEC_W-1:0] sf_s5 [3], w_s5 [3];
	tag_t                    tag_s5;

	always_ff @(posedge clk) begin
		logic [3:0]         k, kc;
		logic signed [45:0] sx;
		if (adv) begin
			k = 4'd0;
			for (int i = 0; i < 3; i++) begin
				kc = fit_shift(s_s4[i]);
				if (kc > k) k = kc;
			end
			for (int i = 0; i < 3; i++) begin
				sx = s_s4[i] >>> k;
				sf_s5[i] <= sx[31:0];
			end
			w_s5   <= w_s4;
			tag_s5 <= tag_s4;
		end
	end

	// s6: partial products of s x w
	logic signed [63:0] pa_s6 [3], pb_s6 [3];
	tag_t               tag_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s6[0] <= sf_s5[1] * w_s5[2];
			pb_s6[0] <= sf_s5[2] * w_s5[1];
			pa_s6[1] <= sf_s5[2] * w_s5[0];
			pb_s6[1] <= sf_s5[0] * w_s5[2];
			pa_s6[2] <= sf_s5[0] * w_s5[1];
			pb_s6[2] <= sf_s5[1] * w_s5[0];
			tag_s6   <= tag_s5;
		end
	end

	// s7: raw normal, operand order swapped for right and bottom planes
	logic signed [64:0] n_s7 [3];
	tag_t               tag_s7;

	logic flip_s6;
	assign flip_s6 = (tag_s6.idx == PLANE_RIGHT) || (tag_s6.idx == PLANE_BOTTOM);

	always_ff @(posedge clk) begin
		logic signed [64:0] d;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				d = 65'(pa_s6[i]) - 65'(pb_s6[i]);
				n_s7[i] <= flip_s6 ? -d : d;
			end
			tag_s7 <= tag_s6;
		end
	end

	// s8: leading bit of the largest magnitude
	logic signed [64:0] n_s8 [3];
	logic [5:0]         h_s8;
	logic               deg_s8;
	tag_t               tag_s8;

	always_ff @(posedge clk) begin
		logic signed [64:0] nn;
		logic [63:0]        orv;
		if (adv) begin
			orv = '0;
			for (int i = 0; i < 3; i++) begin
				nn  = n_s7[i][64] ? -n_s7[i] : n_s7[i];
				orv = orv | nn[63:0];
			end
			h_s8   <= lead_one(orv);
			deg_s8 <= (orv == '0);
			n_s8   <= n_s7;
			tag_s8 <= tag_s7;
		end
	end

	// s9: common shift that puts the top bit at position 29
	logic signed [31:0] ns_s9 [3];
	logic               rs_s9, deg_s9;
	tag_t               tag_s9;

	always_ff @(posedge clk) begin
		logic signed [64:0] sr, sl;
		logic [5:0]         rsh, lsh;
		logic               rs;
		if (adv) begin
			rs  = (h_s8 >= 6'd30);
			rsh = 6'(h_s8 - 6'd29);
			lsh = 6'(6'd29 - h_s8);
			for (int i = 0; i < 3; i++) begin
				sr = n_s8[i] >>> rsh;
				sl = n_s8[i] <<< lsh;
				ns_s9[i] <= rs ? sr[31:0] : sl[31:0];
			end
			rs_s9  <= rs;
			deg_s9 <= deg_s8;
			tag_s9 <= tag_s8;
		end
	end

	// s10: one more shift when a negative component rounded out to 2^30
	logic signed [30:0] nv_s10 [3];
	logic               deg_s10;
	tag_t               tag_s10;

	always_ff @(posedge clk) begin
		logic               big;
		logic signed [31:0] t;
		if (adv) begin
			big = 1'b0;
			for (int i = 0; i < 3; i++) begin
				if (ns_s9[i] <= NORM_MIN || ns_s9[i] >= NORM_LIM) big = 1'b1;
			end
			for (int i = 0; i < 3; i++) begin
				t = (rs_s9 && big) ? (ns_s9[i] >>> 1) : ns_s9[i];
				nv_s10[i] <= t[30:0];
			end
			deg_s10 <= deg_s9;
			tag_s10 <= tag_s9;
		end
	end

	// s11: magnitudes and squares
	logic [2:0][MAG_W-1:0]   mag_s11;
	logic [2*MAG_W-1:0]      sq_s11 [3];
	logic [2:0]              neg_s11;
	logic                    deg_s11;
	tag_t                    tag_s11;

	always_ff @(posedge clk) begin
		logic signed [30:0] a;
		logic [MAG_W-1:0]   m;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				a = nv_s10[i][30] ? -nv_s10[i] : nv_s10[i];
				m = a[MAG_W-1:0];
				mag_s11[i] <= m;
				sq_s11[i]  <= m * m;
				neg_s11[i] <= nv_s10[i][30];
			end
			deg_s11 <= deg_s10;
			tag_s11 <= tag_s10;
		end
	end

	// s12: sum of squares
	logic [SUM_W-1:0]      sum_s12;
	logic [2:0][MAG_W-1:0] mag_s12;
	carry_t                carry_s12;

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s12   <= SUM_W'(sq_s11[0]) + SUM_W'(sq_s11[1]) + SUM_W'(sq_s11[2]);
			mag_s12   <= mag_s11;
			carry_s12 <= '{tag: tag_s11, deg: deg_s11, neg: neg_s11};
		end
	end

	logic [2:0][Q_W-1:0] u_q;
	carry_t              u_carry;

	vfsp_unitize u_unitize (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s12),
		.sum_sq    (sum_s12),
		.mag       (mag_s12),
		.in_carry  (carry_s12),
		.out_valid (u_valid),
		.q         (u_q),
		.out_carry (u_carry)
	);

	// s13: signed unit normal
	logic signed [VEC_W-1:0] nn_s13 [3];
	carry_t                  c_s13;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				nn_s13[i] <= u_carry.neg[i] ? -VEC_W'(u_q[i]) : VEC_W'(u_q[i]);
			end
			c_s13 <= u_carry;
		end
	end

	// s14: normal times position, position split at bit 24
	logic signed [55:0]      pa_s14 [3];
	logic signed [56:0]      pb_s14 [3];
	logic signed [VEC_W-1:0] nn_s14 [3];
	carry_t                  c_s14;

	always_ff @(posedge clk) begin
		logic signed [23:0] ph;
		logic signed [24:0] pl;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				ph = $signed(c_s13.tag.pos[i][47:24]);
				pl = $signed({1'b0, c_s13.tag.pos[i][23:0]});
				pa_s14[i] <= nn_s13[i] * ph;
				pb_s14[i] <= nn_s13[i] * pl;
			end
			nn_s14 <= nn_s13;
			c_s14  <= c_s13;
		end
	end

	// s15: negated dot product halves with rounding term
	logic signed [59:0]      na_s15, nb_s15;
	logic signed [VEC_W-1:0] nn_s15 [3];
	carry_t                  c_s15;

	always_ff @(posedge clk) begin
		logic signed [59:0] a, b;
		if (adv) begin
			a = 60'(pa_s14[0]) + 60'(pa_s14[1]) + 60'(pa_s14[2]);
			b = 60'(pb_s14[0]) + 60'(pb_s14[1]) + 60'(pb_s14[2]);
			na_s15 <= -a;
			nb_s15 <= -b + (60'sd1 <<< 29);
			nn_s15 <= nn_s14;
			c_s15  <= c_s14;
		end
	end

	// output register: offset, saturation, degenerate planes forced to zero
	logic [1:0]              plane_index_q;
	logic signed [VEC_W-1:0] normal_q [3];
	logic signed [POS_W-1:0] offset_q;
	logic                    deg_q;

	always_ff @(posedge clk) begin
		logic signed [59:0] t, off;
		if (adv) begin
			t   = na_s15 + (nb_s15 >>> 24);
			off = t >>> 6;
			if (c_s15.deg) offset_q <= '0;
			else if (off > 60'(OFF_MAX)) offset_q <= OFF_MAX;
			else if (off < 60'(OFF_MIN)) offset_q <= OFF_MIN;
			else offset_q <= off[POS_W-1:0];
			for (int i = 0; i < 3; i++) begin
				normal_q[i] <= c_s15.deg ? '0 : nn_s15[i];
			end
			plane_index_q <= c_s15.tag.idx;
			deg_q         <= c_s15.deg;
		end
	end

	assign plane.valid        = out_v_q;
	assign plane.plane_index  = plane_index_q;
	assign plane.normal_x     = normal_q[0];
	assign plane.normal_y     = normal_q[1];
	assign plane.normal_z     = normal_q[2];
	assign plane.plane_offset = offset_q;
	assign plane.degenerate   = deg_q;
	assign plane.last_plane   = (plane_index_q == PLANE_TOP);

endmodule
